// ----- rtl/bba_pkg.sv -----
package bba_pkg;

  localparam int CNT_W = 13;
  localparam int BLK_W = 12;
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4096);
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_FULL         = 2'd1;
  localparam status_t ST_ALREADY_FREE = 2'd2;
  localparam status_t ST_RANGE        = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [BLK_W-1:0] free_block;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] granted_block;
  } out_word_t;

endpackage

// ----- rtl/bba_ram.sv -----
module bba_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/bba_engine.sv -----
module bba_engine #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [bba_pkg::CNT_W-1:0] eff_cnt,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  bba_pkg::in_word_t       in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bba_pkg::out_word_t      out_word,
  output logic                    rd_en,
  output logic [AW-1:0]           rd_addr,
  input  logic [7:0]              rd_data,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output logic [7:0]              wr_data
);

  localparam int CNT_W = bba_pkg::CNT_W;
  localparam int BLK_W = bba_pkg::BLK_W;
  localparam int CW    = (AW + 3 > CNT_W) ? AW + 3 : CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FREAD, S_FCHK, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]         scan_idx_r, scan_idx_nxt;
  logic                  issue_r, issue_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [AW-1:0]         chk_addr_r, chk_addr_nxt;
  logic [BLK_W-1:0]      blk_r, blk_nxt;
  bba_pkg::out_word_t    res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bba_pkg::out_word_t    out_word_r, out_word_nxt;

  logic [CNT_W+AW-1:0]   last_ext;
  logic [AW-1:0]         last_addr;
  logic [BLK_W+AW-1:0]   free_ext;
  logic [AW-1:0]         free_addr;
  logic [7:0]            free_mask;
  logic [2:0]            zbit;
  logic [AW+2:0]         blk_cand;
  logic                  cand_ok;
  logic                  in_acc;
  logic                  out_free;

  assign last_ext  = (CNT_W + AW)'((eff_cnt - 1'b1) >> 3);
  assign last_addr = last_ext[AW-1:0];
  assign free_ext  = (BLK_W + AW)'(blk_r >> 3);
  assign free_addr = free_ext[AW-1:0];
  assign free_mask = 8'd1 << blk_r[2:0];

  always_comb begin
    zbit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rd_data[i]) zbit = 3'(i);
    end
  end

  assign blk_cand = {chk_addr_r, zbit};
  assign cand_ok  = CW'(blk_cand) < CW'(eff_cnt);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    scan_idx_nxt  = scan_idx_r;
    issue_nxt     = issue_r;
    chk_v_nxt     = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    blk_nxt       = blk_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    rd_en         = 1'b0;
    rd_addr       = scan_idx_r;
    wr_en         = 1'b0;
    wr_addr       = chk_addr_r;
    wr_data       = rd_data;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = 8'd0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          blk_nxt = in_word.free_block;
          res_nxt.granted_block = '0;
          if (in_word.req_type == bba_pkg::REQ_ALLOC) begin
            if (eff_cnt == '0) begin
              res_nxt.status = bba_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              scan_idx_nxt = '0;
              issue_nxt    = 1'b1;
              state_nxt    = S_SCAN;
            end
          end else if (CNT_W'(in_word.free_block) >= eff_cnt) begin
            res_nxt.status = bba_pkg::ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FREAD;
          end
        end
      end
      S_SCAN: begin
        rd_en        = issue_r;
        rd_addr      = scan_idx_r;
        chk_v_nxt    = issue_r;
        chk_addr_nxt = scan_idx_r;
        if (issue_r) begin
          if (scan_idx_r == last_addr) issue_nxt = 1'b0;
          else scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (chk_v_r && rd_data != bba_pkg::FULL_BYTE) begin
          if (cand_ok) begin
            wr_en   = 1'b1;
            wr_data = rd_data | (8'd1 << zbit);
            res_nxt.status        = bba_pkg::ST_OK;
            res_nxt.granted_block = BLK_W'(blk_cand);
          end else begin
            res_nxt.status = bba_pkg::ST_FULL;
          end
          issue_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (chk_v_r && chk_addr_r == last_addr) begin
          res_nxt.status = bba_pkg::ST_FULL;
          issue_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_FREAD: begin
        rd_en     = 1'b1;
        rd_addr   = free_addr;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        wr_addr = free_addr;
        wr_data = rd_data & ~free_mask;
        if ((rd_data & free_mask) == 8'd0) begin
          res_nxt.status = bba_pkg::ST_ALREADY_FREE;
        end else begin
          wr_en = 1'b1;
          res_nxt.status = bba_pkg::ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r <= scan_idx_nxt;
    chk_addr_r <= chk_addr_nxt;
    blk_r      <= blk_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- rtl/block_bitmap_allocator_top.sv -----
// First-fit block allocator over a used-block bitmap held in a byte-wide
// synchronous RAM of (MAX_BLOCKS_HW+7)/8 entries. After reset the RAM is
// cleared one byte per cycle, and no request is taken until that clearing
// pass is done; cfg writes are taken during that time. One request is
// handled at a time. A free reads its byte (S_FREAD), then checks and
// clears its bit (S_FCHK); a range error skips both. An allocate reads one
// byte per cycle from byte 0 until it finds a byte with a clear bit, or
// reports full after the last byte that the count covers. The result
// register lets the next request be accepted while a result still waits to
// be taken.
module block_bitmap_allocator_top #(
  parameter int MAX_BLOCKS_HW = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bba_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bba_pkg::out_word_t        out_word
);

  localparam int CNT_W = bba_pkg::CNT_W;
  localparam int DEPTH = (MAX_BLOCKS_HW + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] block_count_r;
  logic [CNT_W-1:0] eff_cnt;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= bba_pkg::CNT_RESET;
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  assign eff_cnt = (32'(block_count_r) > 32'(MAX_BLOCKS_HW)) ?
                   CNT_W'(MAX_BLOCKS_HW) : block_count_r;

  bba_engine #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_cnt   (eff_cnt),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  bba_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ----- rtl/bba_checker.sv -----
module bba_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bba_pkg::out_word_t out_word
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another in flight");

  // stall input during the clearing pass
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // only a granted allocate carries a block number
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == bba_pkg::ST_FULL ||
                  out_word.status == bba_pkg::ST_ALREADY_FREE ||
                  out_word.status == bba_pkg::ST_RANGE)
    |-> out_word.granted_block == '0)
    else $error("error status with nonzero block");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ----- tb/block_bitmap_allocator_top_test.sv -----
module block_bitmap_allocator_top_test;

  localparam int MAP_BYTES = (bba_pkg::MAX_BLOCKS_DEF + 7) / 8;

  typedef struct {
    bba_pkg::in_word_t w;
    int                gap;
    bit                drain;
  } word_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bba_pkg::CNT_W-1:0] cfg_wdata = bba_pkg::CNT_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  bba_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bba_pkg::out_word_t out_word;

  logic [7:0] used_map [0:MAP_BYTES-1];
  logic [bba_pkg::CNT_W-1:0] cur_count = bba_pkg::CNT_RESET;

  word_slot_t word_queue [$];
  bba_pkg::out_word_t reply_due [0:8191];
  int words_taken = 0;
  int replies_seen = 0;
  int err_cnt = 0;
  int gap_wait = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  int live_est = 0;

  block_bitmap_allocator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_count();
    return (int'(cur_count) > bba_pkg::MAX_BLOCKS_DEF) ?
           bba_pkg::MAX_BLOCKS_DEF : int'(cur_count);
  endfunction

  function automatic bba_pkg::out_word_t next_reply(bba_pkg::in_word_t w);
    int eff;
    int nbytes;
    int i;
    int pos;
    int blk;
    bit hit;
    bba_pkg::out_word_t r;
    eff = eff_count();
    r.status = bba_pkg::ST_FULL;
    r.granted_block = '0;
    if (w.req_type == bba_pkg::REQ_ALLOC) begin
      nbytes = (eff + 7) / 8;
      hit = 1'b0;
      for (i = 0; i < nbytes && !hit; i++) begin
        if (used_map[i] != bba_pkg::FULL_BYTE) begin
          hit = 1'b1;
          pos = 0;
          while (used_map[i][pos]) pos++;
          blk = i * 8 + pos;
          if (blk < eff) begin
            used_map[i][pos] = 1'b1;
            r.status = bba_pkg::ST_OK;
            r.granted_block = bba_pkg::BLK_W'(blk);
          end
        end
      end
    end else begin
      blk = int'(w.free_block);
      if (blk >= eff) begin
        r.status = bba_pkg::ST_RANGE;
      end else if (!used_map[blk / 8][blk % 8]) begin
        r.status = bba_pkg::ST_ALREADY_FREE;
      end else begin
        used_map[blk / 8][blk % 8] = 1'b0;
        r.status = bba_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at reply %0d: %s", replies_seen, msg);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin : drive_words
    word_slot_t nx;
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_wait = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        reply_due[words_taken] <= next_reply(in_word);
        words_taken <= words_taken + 1;
      end
      if (!in_valid || took) begin
        if (word_queue.size() != 0 && gap_wait >= word_queue[0].gap &&
            (!word_queue[0].drain || (!took && words_taken == replies_seen))) begin
          nx = word_queue.pop_front();
          in_word <= nx.w;
          in_valid <= 1'b1;
          gap_wait = 0;
        end else begin
          in_valid <= 1'b0;
          if (word_queue.size() != 0 && gap_wait < word_queue[0].gap) gap_wait++;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_replies
    bba_pkg::out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_seen >= words_taken) begin
          report_mismatch("reply with no request pending");
        end else begin
          e = reply_due[replies_seen];
          if (out_word.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_word.status, e.status));
          if (out_word.granted_block !== e.granted_block)
            report_mismatch($sformatf("granted_block %0d, expected %0d",
                                      out_word.granted_block, e.granted_block));
        end
        replies_seen <= replies_seen + 1;
        stall_left = quiet_rx ? 0 : $urandom_range(0, 13);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_word(logic req, int blk);
    word_slot_t s;
    s.w.req_type = req;
    s.w.free_block = bba_pkg::BLK_W'(blk);
    s.gap = quiet_tx ? 0 : $urandom_range(0, 13);
    s.drain = 1'b0;
    word_queue.push_back(s);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(word_queue.size() == 0 && !in_valid && words_taken == replies_seen));
  endtask

  task automatic set_count(int v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= bba_pkg::CNT_W'(v);
    cur_count = bba_pkg::CNT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_word();
    int k;
    int eff;
    int hi;
    int blk;
    eff = eff_count();
    k = $urandom_range(0, 9);
    blk = $urandom_range(0, 4095);
    if (k < 5) begin
      if (live_est < eff) live_est++;
      queue_word(bba_pkg::REQ_ALLOC, blk);
    end else begin
      if (k < 8) begin
        hi = ((live_est < eff) ? live_est : eff) + 8;
        if (hi > 4095) hi = 4095;
        blk = $urandom_range(0, hi);
        if (live_est > 0) live_est--;
      end else if (k == 9) begin
        blk = (eff == 0) ? $urandom_range(0, 1) : eff - 1 + $urandom_range(0, 2);
        if (blk > 4095) blk = 4095;
      end
      queue_word(bba_pkg::REQ_FREE, blk);
    end
  endtask

  task automatic run_phase(int count, int n, bit qtx, bit qrx, int hold, int drain_at);
    int i;
    set_count(count);
    quiet_tx = qtx;
    quiet_rx = qrx;
    if (live_est > eff_count()) live_est = eff_count();
    for (i = 0; i < n; i++) begin
      queue_random_word();
      if (i == drain_at) word_queue[word_queue.size() - 1].drain = 1'b1;
    end
    hold_cycles = hold;
  endtask

  initial begin
    int i;
    for (i = 0; i < MAP_BYTES; i++) used_map[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count: free of free blocks, grants from the bottom, ignored field
    queue_word(bba_pkg::REQ_FREE, 0);
    queue_word(bba_pkg::REQ_FREE, 4095);
    queue_word(bba_pkg::REQ_ALLOC, 4095);
    queue_word(bba_pkg::REQ_ALLOC, 0);
    queue_word(bba_pkg::REQ_ALLOC, 2730);
    queue_word(bba_pkg::REQ_FREE, 1);
    queue_word(bba_pkg::REQ_ALLOC, 1365);
    queue_word(bba_pkg::REQ_FREE, 2);
    queue_word(bba_pkg::REQ_FREE, 2);

    // zero count: nothing managed
    set_count(0);
    queue_word(bba_pkg::REQ_ALLOC, 0);
    queue_word(bba_pkg::REQ_FREE, 0);
    queue_word(bba_pkg::REQ_FREE, 4095);

    // partial last byte: fill to the count, then full
    set_count(13);
    for (i = 0; i < 12; i++) queue_word(bba_pkg::REQ_ALLOC, 0);
    queue_word(bba_pkg::REQ_FREE, 13);
    queue_word(bba_pkg::REQ_FREE, 12);
    queue_word(bba_pkg::REQ_ALLOC, 0);

    run_phase(8191, 100, 1'b0, 1'b0, 0, -1);
    run_phase(1, 60, 1'b1, 1'b1, 0, -1);
    run_phase(13, 100, 1'b1, 1'b0, 2000, -1);
    run_phase(64, 150, 1'b0, 1'b0, 0, -1);
    run_phase(0, 30, 1'b0, 1'b0, 0, -1);
    run_phase(7, 100, 1'b0, 1'b0, 0, 50);
    run_phase($urandom_range(1, 200), 120, 1'b1, 1'b1, 0, -1);
    run_phase(4095, 100, 1'b0, 1'b0, 0, -1);
    run_phase(9, 100, 1'b0, 1'b0, 0, -1);
    run_phase($urandom_range(1, 8191), 100, 1'b0, 1'b0, 0, -1);
    run_phase(8, 80, 1'b0, 1'b0, 0, -1);
    run_phase(4096, 100, 1'b0, 1'b0, 0, 40);

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("block_bitmap_allocator_top test passed");
    end else begin
      $display("block_bitmap_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("block_bitmap_allocator_top test failed");
    $finish;
  end

endmodule
